@@ hw/rtl/sphere_point_query_top_defines.svh @@
// Assertion macros for the sphere point query block.
`ifndef SPHERE_POINT_QUERY_TOP_DEFINES_SVH
`define SPHERE_POINT_QUERY_TOP_DEFINES_SVH

// Same-cycle implication.
`define SQP_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication.
`define SQP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

@@ hw/rtl/sqp_pkg.sv @@
// Shared types and constants for the sphere point query block.
package sqp_pkg;

   localparam int NUM_AXES = 3;

   typedef enum logic [1:0] {
      REG_CENTER_X = 2'd0,
      REG_CENTER_Y = 2'd1,
      REG_CENTER_Z = 2'd2,
      REG_RADIUS   = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic advance;
      logic valid;
   } flow_type;

endpackage

@@ hw/rtl/sphere_point_query_top.sv @@
// Top level of the sphere point query block: register port, pipeline and result stage.
// Takes one query point per cycle and returns, per point, whether it lies in or on the
// configured sphere and the nearest point on the sphere surface. The pipeline has four
// front stages for offset, squares and the containment test, COORD_WIDTH+1 square-root
// stages at one root bit each, one divider operand stage and COORD_WIDTH-1 divider
// stages at one quotient bit each, and the result register. Throughput is one beat per
// cycle; a stall on the result side freezes the whole pipeline. When the point equals
// the centre, the centre is returned with degenerate set. Write the centre and radius
// registers only while no beats are in flight.
module sphere_point_query_top import sqp_pkg::*; #(
   parameter int COORD_WIDTH = 32,
   localparam int DATA_W = (COORD_WIDTH > 32) ? 64 : 32,
   localparam int ADDR_W = (COORD_WIDTH > 32) ? 5 : 4
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [COORD_WIDTH-1:0]  req_point_x,
   input  logic [COORD_WIDTH-1:0]  req_point_y,
   input  logic [COORD_WIDTH-1:0]  req_point_z,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic                    rsp_inside_res,
   output logic [COORD_WIDTH-1:0]  rsp_nearest_x,
   output logic [COORD_WIDTH-1:0]  rsp_nearest_y,
   output logic [COORD_WIDTH-1:0]  rsp_nearest_z,
   output logic                    rsp_degenerate,
   output logic                    rsp_saturated,
   input  logic                    psel,
   input  logic                    penable,
   input  logic                    pwrite,
   input  logic [ADDR_W-1:0]       paddr,
   input  logic [DATA_W-1:0]       pwdata,
   output logic [DATA_W-1:0]       prdata,
   output logic                    pready
);

   localparam int CW     = COORD_WIDTH;
   localparam int RW     = CW + 1;
   localparam int RMW    = 2 * CW;
   localparam int QW     = CW - 1;
   localparam int SIDE_W = NUM_AXES * RMW + NUM_AXES + 2;
   localparam int DSIDE  = NUM_AXES + 2;

   logic [NUM_AXES-1:0][CW-1:0] center_ff;
   logic [CW-2:0]               radius_ff;
   reg_index_type               reg_idx;
   logic                        csr_write;

   flow_type                    flow;
   flow_type                    flow_rt;
   flow_type                    flow_dv;
   logic                        advance;

   logic [NUM_AXES-1:0][CW-1:0]  point_w;
   logic                         fr_valid, fr_inside, fr_degen;
   logic [2*CW+1:0]              fr_sum;
   logic [NUM_AXES-1:0]          fr_neg;
   logic [NUM_AXES-1:0][RMW-1:0] fr_rm;

   logic                         rt_valid;
   logic [RW-1:0]                rt_root;
   logic [SIDE_W-1:0]            rt_side;
   logic [NUM_AXES-1:0][RMW-1:0] rt_rm;
   logic [DSIDE-1:0]             rt_dside;

   logic                         dv_valid;
   logic [NUM_AXES-1:0][QW-1:0]  dv_quot;
   logic [DSIDE-1:0]             dv_side;
   logic [NUM_AXES-1:0]          dv_neg;
   logic                         dv_inside, dv_degen;

   logic [NUM_AXES-1:0][CW:0]    sum_w;
   logic [NUM_AXES-1:0][CW-1:0]  near_in;
   logic                         sat_in;

   logic                         rsp_valid_ff;
   logic                         inside_ff, degen_ff, sat_ff;
   logic [NUM_AXES-1:0][CW-1:0]  near_ff;

   // register port
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign reg_idx   = reg_index_type'(paddr[ADDR_W-1:ADDR_W-2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         center_ff <= '0;
         radius_ff <= '0;
      end else if (csr_write) begin
         unique case (reg_idx)
            REG_CENTER_X: center_ff[0] <= pwdata[CW-1:0];
            REG_CENTER_Y: center_ff[1] <= pwdata[CW-1:0];
            REG_CENTER_Z: center_ff[2] <= pwdata[CW-1:0];
            REG_RADIUS:   radius_ff    <= pwdata[CW-2:0];
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_CENTER_X: prdata = DATA_W'(center_ff[0]);
         REG_CENTER_Y: prdata = DATA_W'(center_ff[1]);
         REG_CENTER_Z: prdata = DATA_W'(center_ff[2]);
         REG_RADIUS:   prdata = DATA_W'(radius_ff);
      endcase
   end

   // pipeline flow: advance whenever the result register is free or being taken
   assign advance         = !rsp_valid_ff || !rsp_stall;
   assign req_stall       = !advance;
   assign flow.advance    = advance;
   assign flow.valid      = req_valid;
   assign flow_rt.advance = advance;
   assign flow_rt.valid   = fr_valid;
   assign flow_dv.advance = advance;
   assign flow_dv.valid   = rt_valid;

   assign point_w[0] = req_point_x;
   assign point_w[1] = req_point_y;
   assign point_w[2] = req_point_z;

   sqp_front #(.COORD_WIDTH(CW)) u_front (
      .clock      (clock),
      .reset      (reset),
      .flow       (flow),
      .point      (point_w),
      .center     (center_ff),
      .radius     (radius_ff),
      .valid_out  (fr_valid),
      .sum_out    (fr_sum),
      .inside_out (fr_inside),
      .degen_out  (fr_degen),
      .neg_out    (fr_neg),
      .rm_out     (fr_rm)
   );

   sqp_isqrt #(.COORD_WIDTH(CW), .SIDE_W(SIDE_W)) u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .flow      (flow_rt),
      .sum_in    (fr_sum),
      .side_in   ({fr_rm, fr_neg, fr_inside, fr_degen}),
      .valid_out (rt_valid),
      .root_out  (rt_root),
      .side_out  (rt_side)
   );

   assign rt_rm    = rt_side[SIDE_W-1:DSIDE];
   assign rt_dside = rt_side[DSIDE-1:0];

   sqp_div #(.COORD_WIDTH(CW), .SIDE_W(DSIDE)) u_div (
      .clock     (clock),
      .reset     (reset),
      .flow      (flow_dv),
      .len_in    (rt_root),
      .rm_in     (rt_rm),
      .side_in   (rt_dside),
      .valid_out (dv_valid),
      .quot_out  (dv_quot),
      .side_out  (dv_side)
   );

   assign dv_neg    = dv_side[DSIDE-1:2];
   assign dv_inside = dv_side[1];
   assign dv_degen  = dv_side[0];

   // apply signed offset to the centre and clip
   always_comb begin
      sat_in = 1'b0;
      for (int k = 0; k < NUM_AXES; k++) begin
         sum_w[k] = dv_neg[k]
                  ? ({center_ff[k][CW-1], center_ff[k]} - {2'b00, dv_quot[k]})
                  : ({center_ff[k][CW-1], center_ff[k]} + {2'b00, dv_quot[k]});
         if (dv_degen) begin
            near_in[k] = center_ff[k];
         end else if (sum_w[k][CW] != sum_w[k][CW-1]) begin
            near_in[k] = sum_w[k][CW] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
            sat_in     = 1'b1;
         end else begin
            near_in[k] = sum_w[k][CW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= dv_valid;
      end
      if (advance) begin
         near_ff   <= near_in;
         inside_ff <= dv_inside;
         degen_ff  <= dv_degen;
         sat_ff    <= sat_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_inside_res = inside_ff;
   assign rsp_nearest_x  = near_ff[0];
   assign rsp_nearest_y  = near_ff[1];
   assign rsp_nearest_z  = near_ff[2];
   assign rsp_degenerate = degen_ff;
   assign rsp_saturated  = sat_ff;

endmodule

@@ hw/rtl/sqp_front.sv @@
// Offset, squares, radial products, squared length and containment test.
module sqp_front import sqp_pkg::*; #(
   parameter int COORD_WIDTH = 32
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  flow_type                                  flow,
   input  logic [NUM_AXES-1:0][COORD_WIDTH-1:0]      point,
   input  logic [NUM_AXES-1:0][COORD_WIDTH-1:0]      center,
   input  logic [COORD_WIDTH-2:0]                    radius,
   output logic                                      valid_out,
   output logic [2*COORD_WIDTH+1:0]                  sum_out,
   output logic                                      inside_out,
   output logic                                      degen_out,
   output logic [NUM_AXES-1:0]                       neg_out,
   output logic [NUM_AXES-1:0][2*COORD_WIDTH-1:0]    rm_out
);

   localparam int CW   = COORD_WIDTH;
   localparam int MW   = CW + 1;
   localparam int LB   = (MW + 1) / 2;
   localparam int HB   = MW - LB;
   localparam int PLLW = 2 * LB;
   localparam int PLHW = LB + HB;
   localparam int PHHW = 2 * HB;
   localparam int RLW  = CW - 1 + LB;
   localparam int RHW  = CW - 1 + HB;
   localparam int SQW  = 2 * MW;
   localparam int RMW  = 2 * CW;
   localparam int RQW  = 2 * (CW - 1);

   logic [3:0] vld_ff;

   logic [NUM_AXES-1:0][MW-1:0]   diff_w;
   logic [NUM_AXES-1:0][MW-1:0]   mag_in, mag_ff;
   logic [NUM_AXES-1:0]           neg1_in, neg1_ff, neg2_ff, neg3_ff, neg4_ff;

   logic [NUM_AXES-1:0][PLLW-1:0] pll_in, pll_ff;
   logic [NUM_AXES-1:0][PLHW-1:0] plh_in, plh_ff;
   logic [NUM_AXES-1:0][PHHW-1:0] phh_in, phh_ff;
   logic [NUM_AXES-1:0][RLW-1:0]  rml_in, rml_ff;
   logic [NUM_AXES-1:0][RHW-1:0]  rmh_in, rmh_ff;

   logic [NUM_AXES-1:0][SQW-1:0]  sq_in, sq_ff;
   logic [NUM_AXES-1:0][RMW-1:0]  rm_in, rm3_ff, rm4_ff;

   logic [RQW-1:0]                radsq_ff;
   logic [SQW-1:0]                sum_in, sum_ff;
   logic                          inside_ff, degen_ff;

   always_comb begin
      for (int k = 0; k < NUM_AXES; k++) begin
         diff_w[k]  = {point[k][CW-1], point[k]} - {center[k][CW-1], center[k]};
         neg1_in[k] = diff_w[k][MW-1];
         mag_in[k]  = neg1_in[k] ? (~diff_w[k] + MW'(1)) : diff_w[k];
      end
   end

   always_comb begin
      for (int k = 0; k < NUM_AXES; k++) begin
         pll_in[k] = PLLW'(mag_ff[k][LB-1:0]) * PLLW'(mag_ff[k][LB-1:0]);
         plh_in[k] = PLHW'(mag_ff[k][LB-1:0]) * PLHW'(mag_ff[k][MW-1:LB]);
         phh_in[k] = PHHW'(mag_ff[k][MW-1:LB]) * PHHW'(mag_ff[k][MW-1:LB]);
         rml_in[k] = RLW'(radius) * RLW'(mag_ff[k][LB-1:0]);
         rmh_in[k] = RHW'(radius) * RHW'(mag_ff[k][MW-1:LB]);
      end
   end

   always_comb begin
      for (int k = 0; k < NUM_AXES; k++) begin
         sq_in[k] = (SQW'(phh_ff[k]) << (2 * LB)) + (SQW'(plh_ff[k]) << (LB + 1))
                  + SQW'(pll_ff[k]);
         rm_in[k] = (RMW'(rmh_ff[k]) << LB) + RMW'(rml_ff[k]);
      end
      sum_in = sq_ff[0] + sq_ff[1] + sq_ff[2];
   end

   always_ff @(posedge clock) begin
      radsq_ff <= RQW'(radius) * RQW'(radius);
      if (reset) begin
         vld_ff <= '0;
      end else if (flow.advance) begin
         vld_ff <= {vld_ff[2:0], flow.valid};
      end
      if (flow.advance) begin
         mag_ff    <= mag_in;
         neg1_ff   <= neg1_in;
         pll_ff    <= pll_in;
         plh_ff    <= plh_in;
         phh_ff    <= phh_in;
         rml_ff    <= rml_in;
         rmh_ff    <= rmh_in;
         neg2_ff   <= neg1_ff;
         sq_ff     <= sq_in;
         rm3_ff    <= rm_in;
         neg3_ff   <= neg2_ff;
         sum_ff    <= sum_in;
         inside_ff <= (sum_in <= SQW'(radsq_ff));
         degen_ff  <= (sum_in == '0);
         rm4_ff    <= rm3_ff;
         neg4_ff   <= neg3_ff;
      end
   end

   assign valid_out  = vld_ff[3];
   assign sum_out    = sum_ff;
   assign inside_out = inside_ff;
   assign degen_out  = degen_ff;
   assign neg_out    = neg4_ff;
   assign rm_out     = rm4_ff;

endmodule

@@ hw/rtl/sqp_isqrt.sv @@
// Integer square root, one result bit per pipeline stage.
module sqp_isqrt import sqp_pkg::*; #(
   parameter int COORD_WIDTH = 32,
   parameter int SIDE_W      = 8
) (
   input  logic                         clock,
   input  logic                         reset,
   input  flow_type                     flow,
   input  logic [2*COORD_WIDTH+1:0]     sum_in,
   input  logic [SIDE_W-1:0]            side_in,
   output logic                         valid_out,
   output logic [COORD_WIDTH:0]         root_out,
   output logic [SIDE_W-1:0]            side_out
);

   localparam int RW = COORD_WIDTH + 1;
   localparam int SW = 2 * RW;
   localparam int TW = RW + 4;

   logic [RW-1:0]     vld_ff;
   logic [RW+1:0]     rem_ff  [RW];
   logic [RW-1:0]     root_ff [RW];
   logic [SW-1:0]     sh_ff   [RW];
   logic [SIDE_W-1:0] side_ff [RW];

   for (genvar j = 0; j < RW; j++) begin : g_stage
      logic [RW+1:0]     rem_prev;
      logic [RW-1:0]     root_prev;
      logic [SW-1:0]     sh_prev;
      logic [SIDE_W-1:0] side_prev;
      logic              vld_prev;
      logic [TW-1:0]     cur, trial, diff;
      logic              take;

      if (j == 0) begin : g_first
         assign rem_prev  = '0;
         assign root_prev = '0;
         assign sh_prev   = sum_in;
         assign side_prev = side_in;
         assign vld_prev  = flow.valid;
      end else begin : g_next
         assign rem_prev  = rem_ff[j-1];
         assign root_prev = root_ff[j-1];
         assign sh_prev   = sh_ff[j-1];
         assign side_prev = side_ff[j-1];
         assign vld_prev  = vld_ff[j-1];
      end

      always_comb begin
         cur   = {rem_prev, sh_prev[SW-1:SW-2]};
         trial = {2'b00, root_prev, 2'b01};
         diff  = cur - trial;
         take  = (cur >= trial);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[j] <= 1'b0;
         end else if (flow.advance) begin
            vld_ff[j] <= vld_prev;
         end
         if (flow.advance) begin
            rem_ff[j]  <= take ? diff[RW+1:0] : cur[RW+1:0];
            root_ff[j] <= {root_prev[RW-2:0], take};
            sh_ff[j]   <= {sh_prev[SW-3:0], 2'b00};
            side_ff[j] <= side_prev;
         end
      end
   end

   assign valid_out = vld_ff[RW-1];
   assign root_out  = root_ff[RW-1];
   assign side_out  = side_ff[RW-1];

endmodule

@@ hw/rtl/sqp_div.sv @@
// Rounded radial scaling: restoring division, one quotient bit per stage, three lanes.
module sqp_div import sqp_pkg::*; #(
   parameter int COORD_WIDTH = 32,
   parameter int SIDE_W      = 5
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  flow_type                                  flow,
   input  logic [COORD_WIDTH:0]                      len_in,
   input  logic [NUM_AXES-1:0][2*COORD_WIDTH-1:0]    rm_in,
   input  logic [SIDE_W-1:0]                         side_in,
   output logic                                      valid_out,
   output logic [NUM_AXES-1:0][COORD_WIDTH-2:0]      quot_out,
   output logic [SIDE_W-1:0]                         side_out
);

   localparam int CW = COORD_WIDTH;
   localparam int NW = 2 * CW + 2;
   localparam int DW = CW + 2;
   localparam int QW = CW - 1;

   logic                          pvld_ff;
   logic [NUM_AXES-1:0][NW-1:0]   pnum_ff;
   logic [DW-1:0]                 pden_ff;
   logic [SIDE_W-1:0]             pside_ff;

   logic [QW-1:0]                 vld_ff;
   logic [NUM_AXES-1:0][NW-1:0]   r_ff    [QW];
   logic [NUM_AXES-1:0][QW-1:0]   q_ff    [QW];
   logic [DW-1:0]                 den_ff  [QW];
   logic [SIDE_W-1:0]             side_ff [QW];

   always_ff @(posedge clock) begin
      if (reset) begin
         pvld_ff <= 1'b0;
      end else if (flow.advance) begin
         pvld_ff <= flow.valid;
      end
      if (flow.advance) begin
         for (int k = 0; k < NUM_AXES; k++) begin
            pnum_ff[k] <= {1'b0, rm_in[k], 1'b0} + NW'(len_in);
         end
         pden_ff  <= {len_in, 1'b0};
         pside_ff <= side_in;
      end
   end

   for (genvar j = 0; j < QW; j++) begin : g_stage
      localparam int SH = QW - 1 - j;
      logic [NUM_AXES-1:0][NW-1:0] r_prev, r_next;
      logic [NUM_AXES-1:0][QW-1:0] q_prev, q_next;
      logic [DW-1:0]               den_prev;
      logic [SIDE_W-1:0]           side_prev;
      logic                        vld_prev;
      logic [NW-1:0]               dsh;

      if (j == 0) begin : g_first
         assign r_prev    = pnum_ff;
         assign q_prev    = '0;
         assign den_prev  = pden_ff;
         assign side_prev = pside_ff;
         assign vld_prev  = pvld_ff;
      end else begin : g_next
         assign r_prev    = r_ff[j-1];
         assign q_prev    = q_ff[j-1];
         assign den_prev  = den_ff[j-1];
         assign side_prev = side_ff[j-1];
         assign vld_prev  = vld_ff[j-1];
      end

      always_comb begin
         dsh = NW'(den_prev) << SH;
         for (int k = 0; k < NUM_AXES; k++) begin
            if (r_prev[k] >= dsh) begin
               r_next[k] = r_prev[k] - dsh;
               q_next[k] = {q_prev[k][QW-2:0], 1'b1};
            end else begin
               r_next[k] = r_prev[k];
               q_next[k] = {q_prev[k][QW-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[j] <= 1'b0;
         end else if (flow.advance) begin
            vld_ff[j] <= vld_prev;
         end
         if (flow.advance) begin
            r_ff[j]    <= r_next;
            q_ff[j]    <= q_next;
            den_ff[j]  <= den_prev;
            side_ff[j] <= side_prev;
         end
      end
   end

   assign valid_out = vld_ff[QW-1];
   assign quot_out  = q_ff[QW-1];
   assign side_out  = side_ff[QW-1];

endmodule

@@ hw/rtl/sqp_checker.sv @@
// Port-level checks for the sphere point query block, bound to the top level.
`include "sphere_point_query_top_defines.svh"

module sqp_checker #(
   parameter int COORD_WIDTH = 32
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_stall,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input logic                   rsp_inside_res,
   input logic [COORD_WIDTH-1:0] rsp_nearest_x,
   input logic [COORD_WIDTH-1:0] rsp_nearest_y,
   input logic [COORD_WIDTH-1:0] rsp_nearest_z,
   input logic                   rsp_degenerate,
   input logic                   rsp_saturated
);

   `SQP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)
   `SQP_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && rsp_stall, $stable(rsp_nearest_x) && $stable(rsp_nearest_y) && $stable(rsp_nearest_z) && $stable(rsp_inside_res) && $stable(rsp_degenerate) && $stable(rsp_saturated))
   `SQP_ASSERT_IMPLY(a_stall_link, clock, reset, 1'b1, req_stall == (rsp_valid && rsp_stall))
   `SQP_ASSERT_IMPLY(a_degen_inside, clock, reset, rsp_valid && rsp_degenerate, rsp_inside_res)
   `SQP_ASSERT_IMPLY(a_degen_no_sat, clock, reset, rsp_valid && rsp_degenerate, !rsp_saturated)

endmodule

bind sphere_point_query_top sqp_checker #(.COORD_WIDTH(COORD_WIDTH)) u_sqp_checker (.*);

@@ tb/sphere_point_query_top_test.sv @@
// Stimulus, sphere query predictor and result checking for the sphere point query block.
module sphere_point_query_top_test import sqp_pkg::*;;

   localparam int LATENCY = 70;
   localparam int WATCHDOG_LIMIT = 20000;

   typedef struct packed {
      logic [31:0] x;
      logic [31:0] y;
      logic [31:0] z;
   } query_beat_type;

   typedef struct packed {
      logic        inside_res;
      logic [31:0] nearest_x;
      logic [31:0] nearest_y;
      logic [31:0] nearest_z;
      logic        degenerate;
      logic        saturated;
   } answer_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [31:0] req_point_x = '0, req_point_y = '0, req_point_z = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic rsp_inside_res, rsp_degenerate, rsp_saturated;
   logic [31:0] rsp_nearest_x, rsp_nearest_y, rsp_nearest_z;
   logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [3:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   sphere_point_query_top dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   logic signed [31:0] centre [3];
   logic [30:0] radius;
   query_beat_type pending_queries [$];
   answer_type expected_answers [$];
   int errors = 0;
   int idle_pct = 6;
   int quiet_cycles = 0;
   bit sender_hold = 1'b0;

   function automatic void queue_query(query_beat_type q);
      pending_queries.insert(pending_queries.size(), q);
   endfunction

   function automatic logic [63:0] root_of(logic [127:0] s);
      logic [63:0] r, c;
      r = '0;
      for (int b = 63; b >= 0; b--) begin
         c = r | (64'd1 << b);
         if ({64'd0, c} * {64'd0, c} <= s) r = c;
      end
      return r;
   endfunction

   function automatic answer_type nearest_on_sphere(query_beat_type q);
      answer_type a;
      logic signed [33:0] d [3];
      logic signed [33:0] r;
      logic [32:0] m [3];
      logic [127:0] s, num, q128;
      logic [63:0] l;
      logic [31:0] p [3];
      p[0] = q.x; p[1] = q.y; p[2] = q.z;
      s = '0;
      for (int k = 0; k < 3; k++) begin
         d[k] = $signed({{2{p[k][31]}}, p[k]}) - $signed({{2{centre[k][31]}}, centre[k]});
         m[k] = d[k] < 0 ? 33'(-d[k]) : 33'(d[k]);
         s += {95'd0, m[k]} * {95'd0, m[k]};
      end
      a = '0;
      a.degenerate = (s == 0);
      a.inside_res = s <= {97'd0, radius} * {97'd0, radius};
      l = a.degenerate ? 64'd0 : root_of(s);
      for (int k = 0; k < 3; k++) begin
         r = {{2{centre[k][31]}}, centre[k]};
         if (!a.degenerate) begin
            num = {97'd0, radius} * {95'd0, m[k]};
            q128 = (2 * num + {64'd0, l}) / ({64'd0, l} * 2);
            r = d[k] < 0 ? r - $signed({2'b00, q128[31:0]}) : r + $signed({2'b00, q128[31:0]});
            if (r > 34'sd2147483647) begin r = 34'sd2147483647; a.saturated = 1'b1; end
            if (r < -34'sd2147483648) begin r = -34'sd2147483648; a.saturated = 1'b1; end
         end
         case (k)
            0: a.nearest_x = r[31:0];
            1: a.nearest_y = r[31:0];
            default: a.nearest_z = r[31:0];
         endcase
      end
      return a;
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!(req_valid && req_stall)) begin
         if (req_valid) expected_answers.insert(expected_answers.size(),
            nearest_on_sphere({req_point_x, req_point_y, req_point_z}));
         if (pending_queries.size() > 0 && !sender_hold && $urandom_range(99) >= idle_pct) begin
            req_valid <= 1'b1;
            {req_point_x, req_point_y, req_point_z} <= pending_queries.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      answer_type got, exp;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_inside_res, rsp_nearest_x, rsp_nearest_y, rsp_nearest_z, rsp_degenerate,
               rsp_saturated};
            if (expected_answers.size() == 0) begin
               $error("unexpected beat");
               errors++;
            end else begin
               exp = expected_answers.pop_front();
               if (got.inside_res !== exp.inside_res) begin
                  $error("inside_res exp %0d got %0d", exp.inside_res, got.inside_res); errors++;
               end
               if (got.nearest_x !== exp.nearest_x) begin
                  $error("nearest_x exp %h got %h", exp.nearest_x, got.nearest_x); errors++;
               end
               if (got.nearest_y !== exp.nearest_y) begin
                  $error("nearest_y exp %h got %h", exp.nearest_y, got.nearest_y); errors++;
               end
               if (got.nearest_z !== exp.nearest_z) begin
                  $error("nearest_z exp %h got %h", exp.nearest_z, got.nearest_z); errors++;
               end
               if (got.degenerate !== exp.degenerate) begin
                  $error("degenerate exp %0d got %0d", exp.degenerate, got.degenerate); errors++;
               end
               if (got.saturated !== exp.saturated) begin
                  $error("saturated exp %0d got %0d", exp.saturated, got.saturated); errors++;
               end
            end
         end
         rsp_stall <= ($urandom_range(99) < idle_pct);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || psel) quiet_cycles <= 0;
         else quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   task automatic csr_write(reg_index_type idx, logic [31:0] value);
      @(posedge clock);
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= 4'(idx) << 2; pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      case (idx)
         REG_CENTER_X: centre[0] = value;
         REG_CENTER_Y: centre[1] = value;
         REG_CENTER_Z: centre[2] = value;
         default: radius = value[30:0];
      endcase
   endtask

   task automatic drain;
      while (pending_queries.size() > 0 || req_valid || expected_answers.size() > 0)
         @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
   endtask

   task automatic set_sphere(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz, logic [31:0] r);
      csr_write(REG_CENTER_X, cx);
      csr_write(REG_CENTER_Y, cy);
      csr_write(REG_CENTER_Z, cz);
      csr_write(REG_RADIUS, r);
   endtask

   function automatic logic [31:0] near_value(logic [31:0] base);
      case ($urandom_range(3))
         0: return $urandom;
         1: return base + 32'($urandom_range(65535)) - 32'd32768;
         2: return base + ($urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000);
         default: return base + {{8{1'b0}}, 24'($urandom)} - 32'h0080_0000;
      endcase
   endfunction

   initial begin
      logic [31:0] cx, cy, cz, rr;
      centre[0] = 0; centre[1] = 0; centre[2] = 0; radius = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      // directed: extremes, centre, zero radius, saturation
      set_sphere(32'h0001_0000, 32'hffff_0000, 32'h0, 32'h0002_0000);
      queue_query({32'h0001_0000, 32'hffff_0000, 32'h0});
      queue_query({32'h0003_0000, 32'hffff_0000, 32'h0});
      queue_query({32'h0002_0000, 32'h0, 32'h0001_0000});
      queue_query({32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff});
      queue_query({32'h8000_0000, 32'h8000_0000, 32'h8000_0000});
      queue_query({32'h0, 32'h0, 32'h0});
      queue_query({32'hffff_ffff, 32'h0, 32'h5555_5555});
      drain();
      set_sphere(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_0000, 32'h7fff_ffff);
      queue_query({32'h7fff_ffff, 32'h8000_0000, 32'h7fff_0000});
      queue_query({32'h8000_0000, 32'h7fff_ffff, 32'h0});
      queue_query({32'h7fff_fffe, 32'h8000_0001, 32'h7fff_0001});
      queue_query({32'h0, 32'h0, 32'h0});
      queue_query({32'haaaa_aaaa, 32'h5555_5555, 32'hffff_ffff});
      drain();
      set_sphere(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h0);
      queue_query({32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000});
      queue_query({32'h8000_0001, 32'h7fff_ffff, 32'h8000_0000});
      queue_query({32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff});
      queue_query({32'h1234_5678, 32'h9abc_def0, 32'h0});
      // hold off the sender until every result is back
      while (pending_queries.size() > 2) @(posedge clock);
      sender_hold = 1'b1;
      while (req_valid || expected_answers.size() > 0) @(posedge clock);
      sender_hold = 1'b0;
      drain();
      for (int ph = 0; ph < 8; ph++) begin
         cx = $urandom; cy = $urandom; cz = $urandom;
         rr = ph % 4 == 0 ? $urandom : {16'd0, 16'($urandom)} << $urandom_range(15);
         if (ph == 5) begin cx = 0; cy = 0; cz = 0; rr = 32'hffff_ffff; end
         set_sphere(cx, cy, cz, rr);
         idle_pct = (ph == 3) ? 0 : 6;
         for (int i = 0; i < 150; i++) begin
            if ($urandom_range(19) == 0)
               queue_query({cx, cy, cz});
            else
               queue_query({near_value(cx), near_value(cy), near_value(cz)});
         end
         drain();
      end
      if (errors == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end
endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/sqp_pkg.sv
hw/rtl/sqp_front.sv
hw/rtl/sqp_isqrt.sv
hw/rtl/sqp_div.sv
hw/rtl/sphere_point_query_top.sv
hw/rtl/sqp_checker.sv
tb/sphere_point_query_top_test.sv
